// ----- rtl/ll1pp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LL(1) predictive parser package
// Grammar tables, widths, status codes and the control/status bundles
// shared between the parser controller and its datapath.
// ----------------------------------------------------------------------------
package ll1pp_pkg;

   // Symbol stack geometry.
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

   // Grammar dimensions.
   localparam int NUM_TERMS = 17;
   localparam int NUM_NTS   = 15;
   localparam int NUM_PRODS = 28;   // production 0 means "no entry"
   localparam int MAX_BODY  = 7;
   localparam int TOK_W     = 5;
   localparam int SYM_W     = 6;
   localparam int PROD_W    = 5;
   localparam int LEN_W     = 3;
   localparam int NT_W      = 4;
   localparam int EXP_W     = 5;
   localparam int STATUS_W  = 3;

   localparam logic [SYM_W-1:0] SYM_EOF   = 6'd0;
   localparam logic [SYM_W-1:0] SYM_START = 6'd17;
   localparam logic [EXP_W-1:0] SAT_EXP   = 5'd31;

   typedef logic [SYM_W-1:0]  sym_type;
   typedef logic [TOK_W-1:0]  tok_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [LEN_W-1:0]  len_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_CONSUMED = 3'd0,
      RSP_ACCEPTED = 3'd1,
      RSP_NO_ENTRY = 3'd2,
      RSP_MISMATCH = 3'd3,
      RSP_OVERFLOW = 3'd4
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_PUSH,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           idle;     // ready for a new token
      logic           pop;      // read the top entry and drop the level
      logic           expand;   // latch the production found for the top
      logic           push;     // write one body symbol
      logic           finish;   // record the status of this token
      logic           reseed;   // restore the eof / start seed
      rsp_status_type code;
      logic           load_out; // move the status into the output register
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic accepted;
      logic level_bad;
      logic top_term;
      logic term_match;
      logic tok_eof;
      logic no_prod;
      logic overflow;
      logic body_empty;
      logic push_last;
      logic out_free;
   } dp_stat_type;

   // Predictive table, indexed [nonterminal][terminal].
   localparam logic [PROD_W-1:0] PRED_TABLE [NUM_NTS][NUM_TERMS] = '{
      '{ 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ 0, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ 0, 3, 3, 0, 0, 4, 0, 4, 0, 0, 0, 4, 0, 0, 0, 0, 0},
      '{ 0, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ 0, 6, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ 0, 0, 0, 0, 0, 8, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ 0, 0, 0,10, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{ 0, 0, 0, 0, 0,11, 0,11, 0, 0, 0,11, 0, 0, 0, 0, 0},
      '{13, 0, 0, 0, 0,12, 0,12, 0, 0,13,12, 0, 0, 0, 0, 0},
      '{ 0, 0, 0, 0, 0,14, 0,15, 0, 0, 0,16, 0, 0, 0, 0, 0},
      '{ 0, 0, 0, 0, 0,17, 0, 0,17, 0, 0, 0, 0, 0, 0, 0,17},
      '{ 0, 0, 0,20, 0, 0, 0, 0, 0,20, 0, 0,18,19, 0, 0, 0},
      '{ 0, 0, 0, 0, 0,21, 0, 0,21, 0, 0, 0, 0, 0, 0, 0,21},
      '{ 0, 0, 0,24, 0, 0, 0, 0, 0,24, 0, 0,24,24,22,23, 0},
      '{ 0, 0, 0, 0, 0,26, 0, 0,25, 0, 0, 0, 0, 0, 0, 0,27}
   };

   localparam logic [LEN_W-1:0] BODY_LEN [NUM_PRODS] = '{
      0, 2, 2, 2, 0, 3, 1, 1, 2, 3, 0, 2, 2, 0, 4, 7, 5, 2, 3, 3, 0, 2, 3, 3, 0, 3, 1, 1
   };

   // Production bodies, left to right; nonterminal n is coded 17 + n.
   localparam logic [SYM_W-1:0] BODY_SYM [NUM_PRODS][MAX_BODY] = '{
      '{ 0,  0,  0,  0,  0,  0,  0},
      '{18, 24,  0,  0,  0,  0,  0},
      '{20, 19,  0,  0,  0,  0,  0},
      '{20, 19,  0,  0,  0,  0,  0},
      '{ 0,  0,  0,  0,  0,  0,  0},
      '{21, 22,  3,  0,  0,  0,  0},
      '{ 1,  0,  0,  0,  0,  0,  0},
      '{ 2,  0,  0,  0,  0,  0,  0},
      '{ 5, 23,  0,  0,  0,  0,  0},
      '{ 4,  5, 23,  0,  0,  0,  0},
      '{ 0,  0,  0,  0,  0,  0,  0},
      '{26, 25,  0,  0,  0,  0,  0},
      '{26, 25,  0,  0,  0,  0,  0},
      '{ 0,  0,  0,  0,  0,  0,  0},
      '{ 5,  6, 27,  3,  0,  0,  0},
      '{ 7,  8, 27,  9, 24, 10, 24},
      '{11,  8, 27,  9, 24,  0,  0},
      '{29, 28,  0,  0,  0,  0,  0},
      '{12, 29, 28,  0,  0,  0,  0},
      '{13, 29, 28,  0,  0,  0,  0},
      '{ 0,  0,  0,  0,  0,  0,  0},
      '{31, 30,  0,  0,  0,  0,  0},
      '{14, 31, 30,  0,  0,  0,  0},
      '{15, 31, 30,  0,  0,  0,  0},
      '{ 0,  0,  0,  0,  0,  0,  0},
      '{ 8, 27,  9,  0,  0,  0,  0},
      '{ 5,  0,  0,  0,  0,  0,  0},
      '{16,  0,  0,  0,  0,  0,  0}
   };

   function automatic prod_type pred_lookup(input logic [NT_W-1:0] nt, input tok_type tok);
      prod_type result;
      result = '0;
      if ((int'(nt) < NUM_NTS) && (int'(tok) < NUM_TERMS)) begin
         result = PRED_TABLE[nt][tok];
      end
      return result;
   endfunction

   function automatic len_type body_length(input prod_type prod);
      len_type result;
      result = '0;
      if (int'(prod) < NUM_PRODS) begin
         result = BODY_LEN[prod];
      end
      return result;
   endfunction

   function automatic sym_type body_symbol(input prod_type prod, input len_type idx);
      sym_type result;
      result = '0;
      if ((int'(prod) < NUM_PRODS) && (int'(idx) < MAX_BODY)) begin
         result = BODY_SYM[prod][idx];
      end
      return result;
   endfunction

endpackage

// ----- rtl/ll1pp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LL(1) parser channel interfaces
// Valid/ready channels for the token stream and the per-token status.
// ----------------------------------------------------------------------------
interface ll1pp_req_if;
   logic                      valid;
   logic                      ready;
   logic [ll1pp_pkg::TOK_W-1:0] token_code;

   modport source (output valid, output token_code, input ready);
   modport sink   (input valid, input token_code, output ready);
endinterface

interface ll1pp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ll1pp_pkg::STATUS_W-1:0] status;
   logic [ll1pp_pkg::EXP_W-1:0]    expansions;

   modport source (output valid, output status, output expansions, input ready);
   modport sink   (input valid, input status, input expansions, output ready);
endinterface

// ----- rtl/ll1pp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ll1pp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ll1pp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LL(1) parser controller
// Sequences pop, table lookup, body pushes and status delivery per token.
// ----------------------------------------------------------------------------
module ll1pp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  ll1pp_pkg::dp_stat_type  stat,
   output ll1pp_pkg::ctrl_cmd_type cmd
);

   ll1pp_pkg::state_type state_ff;
   ll1pp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ll1pp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ll1pp_pkg::S_IDLE: begin
            if (stat.accepted) begin
               state_in = ll1pp_pkg::S_READ;
            end
         end
         ll1pp_pkg::S_READ: begin
            if (stat.level_bad) begin
               state_in = ll1pp_pkg::S_DONE;
            end else begin
               state_in = ll1pp_pkg::S_EVAL;
            end
         end
         ll1pp_pkg::S_EVAL: begin
            if (stat.top_term || stat.no_prod || stat.overflow) begin
               state_in = ll1pp_pkg::S_DONE;
            end else if (stat.body_empty) begin
               state_in = ll1pp_pkg::S_READ;
            end else begin
               state_in = ll1pp_pkg::S_PUSH;
            end
         end
         ll1pp_pkg::S_PUSH: begin
            if (stat.push_last) begin
               state_in = ll1pp_pkg::S_READ;
            end
         end
         ll1pp_pkg::S_DONE: begin
            if (stat.out_free) begin
               state_in = ll1pp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ll1pp_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.code = ll1pp_pkg::RSP_MISMATCH;
      case (state_ff)
         ll1pp_pkg::S_IDLE: begin
            cmd.idle = 1'b1;
         end
         ll1pp_pkg::S_READ: begin
            // An empty or corrupt level is reported as a mismatch.
            cmd.pop    = !stat.level_bad;
            cmd.finish = stat.level_bad;
            cmd.reseed = stat.level_bad;
         end
         ll1pp_pkg::S_EVAL: begin
            if (stat.top_term) begin
               cmd.finish = 1'b1;
               if (!stat.term_match) begin
                  cmd.reseed = 1'b1;
               end else if (stat.tok_eof) begin
                  cmd.code   = ll1pp_pkg::RSP_ACCEPTED;
                  cmd.reseed = 1'b1;
               end else begin
                  cmd.code = ll1pp_pkg::RSP_CONSUMED;
               end
            end else if (stat.no_prod) begin
               cmd.finish = 1'b1;
               cmd.reseed = 1'b1;
               cmd.code   = ll1pp_pkg::RSP_NO_ENTRY;
            end else if (stat.overflow) begin
               cmd.finish = 1'b1;
               cmd.reseed = 1'b1;
               cmd.code   = ll1pp_pkg::RSP_OVERFLOW;
            end else begin
               cmd.expand = 1'b1;
            end
         end
         ll1pp_pkg::S_PUSH: begin
            cmd.push = 1'b1;
         end
         ll1pp_pkg::S_DONE: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            cmd.idle = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/ll1pp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LL(1) parser datapath
// Symbol stack RAM, stack level, grammar ROM lookups, expansion counter
// and the output register of the status channel.
// ----------------------------------------------------------------------------
module ll1pp_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  ll1pp_pkg::ctrl_cmd_type cmd,
   output ll1pp_pkg::dp_stat_type  stat,
   ll1pp_req_if.sink               req_ch,
   ll1pp_rsp_if.source             rsp_ch
);

   localparam int ADDR_W  = ll1pp_pkg::ADDR_W;
   localparam int LEVEL_W = ll1pp_pkg::LEVEL_W;

   ll1pp_pkg::tok_type        token_ff,     token_in;
   logic [LEVEL_W-1:0]        level_ff,     level_in;
   logic                      seeded_ff,    seeded_in;
   logic                      rd_zero_ff,   rd_zero_in;
   logic                      rd_seed_ff,   rd_seed_in;
   ll1pp_pkg::prod_type       prod_ff,      prod_in;
   ll1pp_pkg::len_type        push_idx_ff,  push_idx_in;
   logic [ll1pp_pkg::EXP_W-1:0] exp_ff,     exp_in;
   ll1pp_pkg::rsp_status_type status_ff,    status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ll1pp_pkg::rsp_status_type rsp_status_ff, rsp_status_in;
   logic [ll1pp_pkg::EXP_W-1:0] rsp_exp_ff, rsp_exp_in;

   ll1pp_pkg::sym_type        ram_rd_data;
   ll1pp_pkg::sym_type        top_sym;
   ll1pp_pkg::sym_type        nt_full;
   logic                      top_is_term;
   ll1pp_pkg::prod_type       prod_found;
   ll1pp_pkg::len_type        len_found;
   logic [LEVEL_W:0]          level_after_push;
   logic [ADDR_W-1:0]         rd_addr;
   logic [LEVEL_W-1:0]        level_dec;

   // Entry 0 only ever holds eof, and entry 1 holds the start symbol from
   // a reseed until it is first overwritten, so the seed needs no RAM write.
   assign top_sym = rd_zero_ff ? ll1pp_pkg::SYM_EOF :
                    (rd_seed_ff ? ll1pp_pkg::SYM_START : ram_rd_data);

   assign top_is_term = (int'(top_sym) < ll1pp_pkg::NUM_TERMS);
   assign nt_full     = top_sym - ll1pp_pkg::SYM_START;
   assign prod_found  = top_is_term ? '0 :
                        ll1pp_pkg::pred_lookup(nt_full[ll1pp_pkg::NT_W-1:0], token_ff);
   assign len_found   = ll1pp_pkg::body_length(prod_found);
   assign level_after_push = {1'b0, level_ff} + (LEVEL_W+1)'(len_found);

   assign level_dec = level_ff - LEVEL_W'(1);
   assign rd_addr   = level_dec[ADDR_W-1:0];

   ll1pp_ram #(
      .WIDTH (ll1pp_pkg::SYM_W),
      .DEPTH (ll1pp_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (level_ff[ADDR_W-1:0]),
      .wr_data (ll1pp_pkg::body_symbol(prod_ff, push_idx_ff)),
      .rd_en   (cmd.pop),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      stat            = '0;
      stat.accepted   = req_ch.valid && cmd.idle;
      stat.level_bad  = (level_ff == '0) ||
                        (level_ff > LEVEL_W'(ll1pp_pkg::STACK_DEPTH));
      stat.top_term   = top_is_term;
      stat.term_match = ({1'b0, token_ff} == top_sym);
      stat.tok_eof    = (token_ff == '0);
      // A nonterminal code above the grammar's range also finds no entry.
      stat.no_prod    = (prod_found == '0);
      stat.overflow   = (level_after_push > (LEVEL_W+1)'(ll1pp_pkg::STACK_DEPTH));
      stat.body_empty = (len_found == '0);
      stat.push_last  = (push_idx_ff == '0);
      stat.out_free   = !rsp_valid_ff || rsp_ch.ready;
   end

   always_comb begin
      token_in      = token_ff;
      level_in      = level_ff;
      seeded_in     = seeded_ff;
      rd_zero_in    = rd_zero_ff;
      rd_seed_in    = rd_seed_ff;
      prod_in       = prod_ff;
      push_idx_in   = push_idx_ff;
      exp_in        = exp_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_exp_in    = rsp_exp_ff;

      if (stat.accepted) begin
         token_in = req_ch.token_code;
         exp_in   = '0;
      end

      if (cmd.pop) begin
         level_in   = level_dec;
         rd_zero_in = (level_ff == LEVEL_W'(1));
         rd_seed_in = (level_ff == LEVEL_W'(2)) && seeded_ff;
      end

      if (cmd.expand) begin
         prod_in     = prod_found;
         push_idx_in = len_found - ll1pp_pkg::len_type'(1);
         if (exp_ff != ll1pp_pkg::SAT_EXP) begin
            exp_in = exp_ff + ll1pp_pkg::EXP_W'(1);
         end
      end

      if (cmd.push) begin
         level_in    = level_ff + LEVEL_W'(1);
         push_idx_in = push_idx_ff - ll1pp_pkg::len_type'(1);
         if (level_ff == LEVEL_W'(1)) begin
            seeded_in = 1'b0;
         end
      end

      if (cmd.finish) begin
         status_in = cmd.code;
         if (cmd.reseed) begin
            level_in  = LEVEL_W'(2);
            seeded_in = 1'b1;
         end
      end

      if (cmd.load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_exp_in    = exp_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= LEVEL_W'(2);
         seeded_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      token_ff      <= token_in;
      rd_zero_ff    <= rd_zero_in;
      rd_seed_ff    <= rd_seed_in;
      prod_ff       <= prod_in;
      push_idx_ff   <= push_idx_in;
      exp_ff        <= exp_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_exp_ff    <= rsp_exp_in;
   end

   assign req_ch.ready      = cmd.idle;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.expansions = rsp_exp_ff;

endmodule

// ----- rtl/ll1_predictive_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LL(1) table-driven predictive parser
// Checks a stream of token codes against a fixed grammar held in ROM,
// using a RAM symbol stack, and returns one status per token.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields                         Transfer
// req_ch    in   token_code[4:0]                valid && ready
// rsp_ch    out  status[2:0], expansions[4:0]   valid && ready
//
// A token passes the idle, read, eval and done states when a terminal is on
// top, plus a read, an eval and one push per body symbol for each production
// applied: each stack pop is a registered read of the single stack RAM and
// each body symbol is one RAM write.
// Synchronous reset leaves the stack seeded with eof below the start symbol.
// The next token is taken while a finished status waits in the output
// register; the core stalls before loading a second status until it leaves.
// ----------------------------------------------------------------------------
module ll1_predictive_parser (
   input  logic        clock,
   input  logic        reset,
   ll1pp_req_if.sink   req_ch,
   ll1pp_rsp_if.source rsp_ch
);

   ll1pp_pkg::ctrl_cmd_type cmd;
   ll1pp_pkg::dp_stat_type  stat;

   ll1pp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ll1pp_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .stat   (stat),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- rtl/ll1pp_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LL(1) parser port checker
// Watches the channel ports of the parser over time.
// ----------------------------------------------------------------------------
module ll1pp_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ll1pp_pkg::STATUS_W-1:0] rsp_status,
   input logic [ll1pp_pkg::EXP_W-1:0]    rsp_expansions
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Tokens taken whose status has not yet been transferred.
   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_ready_drops: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("ready stayed high after a token transfer");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 2'd0))
      else $error("status offered with no token outstanding");

   a_two_outstanding: assert property (@(posedge clock) disable iff (reset)
      (pending_ff == 2'd2) |-> !req_ready)
      else $error("token taken with two statuses outstanding");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_expansions)))
      else $error("stalled status changed or was withdrawn");

endmodule

bind ll1_predictive_parser ll1pp_chk u_ll1pp_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_expansions (rsp_ch.expansions)
);

// ----- dv/tb_ll1_predictive_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LL(1) predictive parser testbench
// Feeds token streams to the parser: a short directed table first, then
// random programs built from the grammar, some of them damaged, deeply
// nested or replaced by noise. Every status transfer is checked against a row's fixed
// expectation or an in-bench model of the symbol stack and the predictive grammar.
// ----------------------------------------------------------------------------
module tb_ll1_predictive_parser;

   localparam int RANDOM_ITEMS = 1700;
   localparam int QUIET_ITEMS  = 250;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SETTLE       = 50;

   typedef enum logic [4:0] {
      T_EOF, T_INT, T_FLOAT, T_SEMI, T_COMMA, T_ID, T_BECOMES, T_IF, T_LPAR,
      T_RPAR, T_ELSE, T_WHILE, T_ADD, T_SUB, T_MULT, T_DIV, T_NUM
   } term_code_type;

   // The widest code on the bus is not a terminal of the grammar.
   localparam logic [4:0] TOK_TOP = 5'h1F;

   // Nonterminal symbols as they sit on the stack.
   localparam ll1pp_pkg::sym_type N_PROG     = 6'd17;
   localparam ll1pp_pkg::sym_type N_DECLS    = 6'd18;
   localparam ll1pp_pkg::sym_type N_DECLS_T  = 6'd19;
   localparam ll1pp_pkg::sym_type N_DECL     = 6'd20;
   localparam ll1pp_pkg::sym_type N_TYPE     = 6'd21;
   localparam ll1pp_pkg::sym_type N_IDLIST   = 6'd22;
   localparam ll1pp_pkg::sym_type N_IDLIST_T = 6'd23;
   localparam ll1pp_pkg::sym_type N_STMTS    = 6'd24;
   localparam ll1pp_pkg::sym_type N_STMTS_T  = 6'd25;
   localparam ll1pp_pkg::sym_type N_STMT     = 6'd26;
   localparam ll1pp_pkg::sym_type N_EXPR     = 6'd27;
   localparam ll1pp_pkg::sym_type N_EXPR_T   = 6'd28;
   localparam ll1pp_pkg::sym_type N_TERM     = 6'd29;
   localparam ll1pp_pkg::sym_type N_TERM_T   = 6'd30;
   localparam ll1pp_pkg::sym_type N_FACTOR   = 6'd31;

   typedef ll1pp_pkg::sym_type body_type [ll1pp_pkg::MAX_BODY];

   typedef struct {
      ll1pp_pkg::rsp_status_type status;
      logic [4:0]                expansions;
   } parse_result_type;

   typedef struct {
      logic [4:0]                tok;
      bit                        fixed_on;
      ll1pp_pkg::rsp_status_type status;
      logic [4:0]                expansions;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   ll1pp_req_if req_ch ();
   ll1pp_rsp_if rsp_ch ();

   ll1_predictive_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Model state: the symbol stack and its fill level.
   ll1pp_pkg::sym_type parse_stack [ll1pp_pkg::STACK_DEPTH];
   int                 parse_level;

   parse_result_type awaited_q [$];
   logic [4:0]       prog_tokens [$];

   int mismatch_count = 0;
   int random_sent    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int stall_left     = 0;
   bit quiet_tail     = 1'b0;

   // Rows with fixed_on set carry an expectation that can be read straight
   // off the grammar; the others are left to the model.
   stim_row_type directed_rows [26] = '{
      '{TOK_TOP,   1'b1, ll1pp_pkg::RSP_NO_ENTRY, 5'd0},
      '{T_EOF,     1'b1, ll1pp_pkg::RSP_NO_ENTRY, 5'd0},
      '{T_INT,     1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_ID,      1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_SEMI,    1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_IF,      1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_LPAR,    1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_NUM,     1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_MULT,    1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_ID,      1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_RPAR,    1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_ID,      1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_BECOMES, 1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_NUM,     1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_SEMI,    1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_ELSE,    1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_ID,      1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_BECOMES, 1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_ID,      1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_SEMI,    1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_EOF,     1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_FLOAT,   1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_ID,      1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_SEMI,    1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{T_ID,      1'b0, ll1pp_pkg::RSP_CONSUMED, 5'd0},
      '{TOK_TOP,   1'b1, ll1pp_pkg::RSP_MISMATCH, 5'd0}
   };

   // ------------------------------------------------------------------
   // Grammar model
   // ------------------------------------------------------------------
   function automatic ll1pp_pkg::sym_type term_sym(input logic [4:0] t);
      return {1'b0, t};
   endfunction

   function automatic int pick_rule(input ll1pp_pkg::sym_type top, input logic [4:0] tok);
      int rule;
      rule = 0;
      case (top)
         N_PROG:     if (tok == T_INT || tok == T_FLOAT) rule = 1;
         N_DECLS:    if (tok == T_INT || tok == T_FLOAT) rule = 2;
         N_DECLS_T:
            case (tok)
               T_INT, T_FLOAT:       rule = 3;
               T_ID, T_IF, T_WHILE:  rule = 4;
               default: ;
            endcase
         N_DECL:     if (tok == T_INT || tok == T_FLOAT) rule = 5;
         N_TYPE:
            case (tok)
               T_INT:   rule = 6;
               T_FLOAT: rule = 7;
               default: ;
            endcase
         N_IDLIST:   if (tok == T_ID) rule = 8;
         N_IDLIST_T:
            case (tok)
               T_COMMA: rule = 9;
               T_SEMI:  rule = 10;
               default: ;
            endcase
         N_STMTS:    if (tok == T_ID || tok == T_IF || tok == T_WHILE) rule = 11;
         N_STMTS_T:
            case (tok)
               T_ID, T_IF, T_WHILE: rule = 12;
               T_EOF, T_ELSE:       rule = 13;
               default: ;
            endcase
         N_STMT:
            case (tok)
               T_ID:    rule = 14;
               T_IF:    rule = 15;
               T_WHILE: rule = 16;
               default: ;
            endcase
         N_EXPR:     if (tok == T_ID || tok == T_LPAR || tok == T_NUM) rule = 17;
         N_EXPR_T:
            case (tok)
               T_ADD:          rule = 18;
               T_SUB:          rule = 19;
               T_SEMI, T_RPAR: rule = 20;
               default: ;
            endcase
         N_TERM:     if (tok == T_ID || tok == T_LPAR || tok == T_NUM) rule = 21;
         N_TERM_T:
            case (tok)
               T_MULT:                      rule = 22;
               T_DIV:                       rule = 23;
               T_SEMI, T_RPAR, T_ADD, T_SUB: rule = 24;
               default: ;
            endcase
         N_FACTOR:
            case (tok)
               T_LPAR: rule = 25;
               T_ID:   rule = 26;
               T_NUM:  rule = 27;
               default: ;
            endcase
         default: ;
      endcase
      return rule;
   endfunction

   // Returns the body length; the body is written left to right into b.
   function automatic int rule_body(input int rule, output body_type b);
      int len;
      len = 0;
      b = '{default: '0};
      case (rule)
         1:     begin len = 2; b = '{0: N_DECLS, 1: N_STMTS, default: '0}; end
         2, 3:  begin len = 2; b = '{0: N_DECL, 1: N_DECLS_T, default: '0}; end
         5:     begin
            len = 3;
            b = '{0: N_TYPE, 1: N_IDLIST, 2: term_sym(T_SEMI), default: '0};
         end
         6:     begin len = 1; b = '{0: term_sym(T_INT), default: '0}; end
         7:     begin len = 1; b = '{0: term_sym(T_FLOAT), default: '0}; end
         8:     begin len = 2; b = '{0: term_sym(T_ID), 1: N_IDLIST_T, default: '0}; end
         9:     begin
            len = 3;
            b = '{0: term_sym(T_COMMA), 1: term_sym(T_ID), 2: N_IDLIST_T, default: '0};
         end
         11, 12: begin len = 2; b = '{0: N_STMT, 1: N_STMTS_T, default: '0}; end
         14:    begin
            len = 4;
            b = '{0: term_sym(T_ID), 1: term_sym(T_BECOMES), 2: N_EXPR,
                  3: term_sym(T_SEMI), default: '0};
         end
         15:    begin
            len = 7;
            b = '{0: term_sym(T_IF), 1: term_sym(T_LPAR), 2: N_EXPR,
                  3: term_sym(T_RPAR), 4: N_STMTS, 5: term_sym(T_ELSE),
                  6: N_STMTS};
         end
         16:    begin
            len = 5;
            b = '{0: term_sym(T_WHILE), 1: term_sym(T_LPAR), 2: N_EXPR,
                  3: term_sym(T_RPAR), 4: N_STMTS, default: '0};
         end
         17:    begin len = 2; b = '{0: N_TERM, 1: N_EXPR_T, default: '0}; end
         18:    begin
            len = 3;
            b = '{0: term_sym(T_ADD), 1: N_TERM, 2: N_EXPR_T, default: '0};
         end
         19:    begin
            len = 3;
            b = '{0: term_sym(T_SUB), 1: N_TERM, 2: N_EXPR_T, default: '0};
         end
         21:    begin len = 2; b = '{0: N_FACTOR, 1: N_TERM_T, default: '0}; end
         22:    begin
            len = 3;
            b = '{0: term_sym(T_MULT), 1: N_FACTOR, 2: N_TERM_T, default: '0};
         end
         23:    begin
            len = 3;
            b = '{0: term_sym(T_DIV), 1: N_FACTOR, 2: N_TERM_T, default: '0};
         end
         25:    begin
            len = 3;
            b = '{0: term_sym(T_LPAR), 1: N_EXPR, 2: term_sym(T_RPAR), default: '0};
         end
         26:    begin len = 1; b = '{0: term_sym(T_ID), default: '0}; end
         27:    begin len = 1; b = '{0: term_sym(T_NUM), default: '0}; end
         default: len = 0;
      endcase
      return len;
   endfunction

   function automatic void reseed_stack();
      parse_stack[0] = term_sym(T_EOF);
      parse_stack[1] = N_PROG;
      parse_level = 2;
   endfunction

   // Runs one token through the model stack and returns its status.
   function automatic void parse_token(input logic [4:0] tok,
                                       output ll1pp_pkg::rsp_status_type st,
                                       output logic [4:0] n_exp);
      ll1pp_pkg::sym_type top;
      body_type           body;
      int                 rule;
      int                 len;
      int                 count;
      bit                 done;
      count = 0;
      done  = 1'b0;
      st    = ll1pp_pkg::RSP_MISMATCH;
      while (!done) begin
         done = 1'b1;
         if (parse_level <= 0 || parse_level > ll1pp_pkg::STACK_DEPTH) begin
            st = ll1pp_pkg::RSP_MISMATCH;
            reseed_stack();
         end else begin
            parse_level--;
            top = parse_stack[parse_level];
            if (int'(top) < ll1pp_pkg::NUM_TERMS) begin
               if (top == {1'b0, tok}) begin
                  if (tok == T_EOF) begin
                     st = ll1pp_pkg::RSP_ACCEPTED;
                     reseed_stack();
                  end else begin
                     st = ll1pp_pkg::RSP_CONSUMED;
                  end
               end else begin
                  st = ll1pp_pkg::RSP_MISMATCH;
                  reseed_stack();
               end
            end else begin
               rule = pick_rule(top, tok);
               len  = rule_body(rule, body);
               if (rule == 0) begin
                  st = ll1pp_pkg::RSP_NO_ENTRY;
                  reseed_stack();
               end else if (parse_level + len > ll1pp_pkg::STACK_DEPTH) begin
                  // The production that does not fit is not counted.
                  st = ll1pp_pkg::RSP_OVERFLOW;
                  reseed_stack();
               end else begin
                  for (int i = len - 1; i >= 0; i--) begin
                     parse_stack[parse_level] = body[i];
                     parse_level++;
                  end
                  if (count < int'(ll1pp_pkg::SAT_EXP)) count++;
                  done = 1'b0;
               end
            end
         end
      end
      n_exp = count[4:0];
   endfunction

   // ------------------------------------------------------------------
   // Program generator
   // ------------------------------------------------------------------
   function automatic void emit(input logic [4:0] tok);
      prog_tokens.push_back(tok);
   endfunction

   function automatic void emit_decls();
      repeat ($urandom_range(1, 2)) begin
         emit($urandom_range(0, 1) ? T_INT : T_FLOAT);
         emit(T_ID);
         repeat ($urandom_range(0, 2)) begin
            emit(T_COMMA);
            emit(T_ID);
         end
         emit(T_SEMI);
      end
   endfunction

   function automatic void emit_factor(input int d);
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 3 && d < 3) begin
         emit(T_LPAR);
         emit_expr(d + 1);
         emit(T_RPAR);
      end else begin
         emit(pick == 0 ? T_NUM : T_ID);
      end
   endfunction

   function automatic void emit_term(input int d);
      emit_factor(d);
      repeat ($urandom_range(0, (d < 2) ? 2 : 0)) begin
         emit($urandom_range(0, 1) ? T_MULT : T_DIV);
         emit_factor(d);
      end
   endfunction

   function automatic void emit_expr(input int d);
      emit_term(d);
      repeat ($urandom_range(0, (d < 2) ? 2 : 0)) begin
         emit($urandom_range(0, 1) ? T_ADD : T_SUB);
         emit_term(d);
      end
   endfunction

   function automatic void emit_stmt(input int d);
      int pick;
      pick = (d < 3) ? $urandom_range(0, 4) : 0;
      case (pick)
         3: begin
            emit(T_IF);
            emit(T_LPAR);
            emit_expr(d);
            emit(T_RPAR);
            emit_stmts(d + 1);
            emit(T_ELSE);
            emit_stmts(d + 1);
         end
         4: begin
            emit(T_WHILE);
            emit(T_LPAR);
            emit_expr(d);
            emit(T_RPAR);
            emit_stmts(d + 1);
         end
         default: begin
            emit(T_ID);
            emit(T_BECOMES);
            emit_expr(d);
            emit(T_SEMI);
         end
      endcase
   endfunction

   function automatic void emit_stmts(input int d);
      repeat ((d < 3) ? $urandom_range(1, 2) : 1) emit_stmt(d);
   endfunction

   function automatic void build_program();
      int form;
      int n;
      int cut;
      form = $urandom_range(0, 19);
      emit_decls();
      if (form == 0) begin
         // Deep while nesting: eof then unwinds one empty production per level,
         // which can saturate the count or, past the stack depth, overflow.
         n = $urandom_range(20, 70);
         repeat (n) begin
            emit(T_WHILE);
            emit(T_LPAR);
            emit(T_ID);
            emit(T_RPAR);
         end
         emit(T_ID);
         emit(T_BECOMES);
         emit(T_NUM);
         emit(T_SEMI);
      end else if (form == 1) begin
         // Deep parentheses grow the stack by three symbols per level.
         n = $urandom_range(8, 26);
         emit(T_ID);
         emit(T_BECOMES);
         repeat (n) emit(T_LPAR);
         emit(T_NUM);
         repeat (n) emit(T_RPAR);
         emit(T_SEMI);
      end else begin
         emit_stmts(0);
      end
      emit(T_EOF);
      case ($urandom_range(0, 9))
         0: prog_tokens[$urandom_range(0, prog_tokens.size() - 1)] =
               5'($urandom_range(0, 31));
         1: begin
            cut = $urandom_range(1, prog_tokens.size() - 1);
            prog_tokens = prog_tokens[0:cut-1];
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Token channel
   // ------------------------------------------------------------------
   task automatic send_token(input logic [4:0] tok, input bit fixed_on,
                             input ll1pp_pkg::rsp_status_type fixed_status,
                             input logic [4:0] fixed_exp);
      parse_result_type predicted;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.token_code <= tok;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      parse_token(tok, predicted.status, predicted.expansions);
      if (fixed_on) begin
         predicted.status     = fixed_status;
         predicted.expansions = fixed_exp;
      end
      awaited_q.push_back(predicted);
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (awaited_q.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Status channel: checking, backpressure and the cycle limit
   // ------------------------------------------------------------------
   function automatic void check_result();
      parse_result_type want;
      if (awaited_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected status transfer: status %0d expansions %0d",
                     rsp_ch.status, rsp_ch.expansions);
      end else begin
         want = awaited_q.pop_front();
         if (rsp_ch.status !== want.status || rsp_ch.expansions !== want.expansions) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("status mismatch: expected %0d/%0d, got %0d/%0d",
                        want.status, want.expansions, rsp_ch.status, rsp_ch.expansions);
         end
      end
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_result();
         if (cycle_count % 256 == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               default: stall_pct = 40;
            endcase
         end
         if (!quiet_tail && stall_left == 0 && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 8);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.token_code = '0;
      reseed_stack();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      foreach (directed_rows[i])
         send_token(directed_rows[i].tok, directed_rows[i].fixed_on,
                    directed_rows[i].status, directed_rows[i].expansions);
      hold_until_drained();

      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet_tail    = 1'b1;
            send_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       send_idle_pct = 0;
               1:       send_idle_pct = 15;
               default: send_idle_pct = 50;
            endcase
         end
         prog_tokens.delete();
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(3, 10)) emit(5'($urandom_range(0, 31)));
         end else begin
            build_program();
         end
         foreach (prog_tokens[i]) begin
            send_token(prog_tokens[i], 1'b0, ll1pp_pkg::RSP_CONSUMED, '0);
            random_sent++;
         end
         if (!quiet_tail && $urandom_range(0, 9) == 0) hold_until_drained();
      end

      req_ch.valid <= 1'b0;
      while (awaited_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0 && awaited_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
